// ===== hw/rtl/ffsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and defaults for the first-fit segment allocator.
package ffsa_pkg;

    // Fixed field widths of the request and result channels
    localparam int ADDR_W   = 12;
    localparam int SIZE_W   = 12;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 13;

    // Defaults for the top-level parameters
    localparam int MAX_SEGMENTS_DEF    = 64;
    localparam int ARENA_MAX_WORDS_DEF = 4096;
    localparam int START_WORDS_DEF     = 8;

    // Capacity must exceed this before a free may halve it
    localparam int SHRINK_ABOVE = 8;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } ffsa_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2
    } ffsa_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CMP,
        S_GROW,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_FREE_RD,
        S_FREE_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_SHR_CHK,
        S_SHR_RD,
        S_SHR_CMP,
        S_DONE
    } ffsa_state_t;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } ffsa_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        ffsa_status_t      status;
        logic [WORD_W-1:0] used_words;
        logic [WORD_W-1:0] capacity_now;
    } ffsa_rsp_t;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic idle;
        logic done;
    } ffsa_ctrl_st_t;

    // Result of the shared compare unit: c against a + b
    typedef struct packed {
        logic ge;
        logic eq;
    } ffsa_cmp_t;

endpackage

// ===== hw/rtl/ffsa_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the first-fit segment allocator.
interface ffsa_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [ffsa_pkg::SIZE_W-1:0] request_size;
    logic [ffsa_pkg::ADDR_W-1:0] free_address;

    modport source (
        output valid,
        output req_type,
        output request_size,
        output free_address,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  request_size,
        input  free_address,
        output ready
    );
endinterface

// ===== hw/rtl/ffsa_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel of the first-fit segment allocator.
interface ffsa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffsa_pkg::ADDR_W-1:0]   granted_address;
    logic [ffsa_pkg::STATUS_W-1:0] status;
    logic [ffsa_pkg::WORD_W-1:0]   used_words;
    logic [ffsa_pkg::WORD_W-1:0]   capacity_now;

    modport source (
        output valid,
        output granted_address,
        output status,
        output used_words,
        output capacity_now,
        input  ready
    );

    modport sink (
        input  valid,
        input  granted_address,
        input  status,
        input  used_words,
        input  capacity_now,
        output ready
    );
endinterface

// ===== hw/rtl/ffsa_alu.sv =====
`timescale 1ns / 1ps
// Shared add-and-compare unit: compares c against a + b.
module ffsa_alu #(
    parameter int W = 14
) (
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    input  logic [W-1:0]        c,
    output ffsa_pkg::ffsa_cmp_t res
);

    logic [W:0] sum;
    logic [W:0] c_ext;

    assign sum    = {1'b0, a} + {1'b0, b};
    assign c_ext  = {1'b0, c};
    assign res.ge = (c_ext >= sum);
    assign res.eq = (c_ext == sum);

endmodule

// ===== hw/rtl/ffsa_seg_mem.sv =====
`timescale 1ns / 1ps
// Segment table memory: one write port, one registered read port.
module ffsa_seg_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/ffsa_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer that scans, shifts and sizes the segment table with one compare unit.
module ffsa_ctrl #(
    parameter int MAX_SEGMENTS    = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ARENA_MAX_WORDS = ffsa_pkg::ARENA_MAX_WORDS_DEF,
    parameter int START_WORDS     = ffsa_pkg::START_WORDS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ffsa_pkg::ffsa_req_t     req,
    input  logic                    start,
    input  logic                    done_ack,
    output ffsa_pkg::ffsa_ctrl_st_t st,
    output ffsa_pkg::ffsa_rsp_t     rsp
);

    localparam int CNT_W    = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W    = $clog2(MAX_SEGMENTS);
    localparam int CAP_W    = $clog2(ARENA_MAX_WORDS + 1);
    localparam int AW       = $clog2(ARENA_MAX_WORDS);
    localparam int DW       = 2 * AW;
    localparam int NEED_W   = ffsa_pkg::SIZE_W + 1;
    localparam int SUM_W    = ((CAP_W > NEED_W) ? CAP_W : NEED_W) + 1;
    localparam int HALF_MAX = ARENA_MAX_WORDS / 2;

    ffsa_pkg::ffsa_state_t  state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic [CAP_W-1:0]       work_cap_reg, work_cap_next;
    logic [CAP_W-1:0]       used_reg, used_next;
    logic [CAP_W-1:0]       base_reg, base_next;
    logic [NEED_W-1:0]      need_reg, need_next;
    logic [ffsa_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ffsa_pkg::ADDR_W-1:0] grant_reg, grant_next;
    ffsa_pkg::ffsa_status_t status_reg, status_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [DW-1:0]    mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [DW-1:0]    mem_rdata;

    logic [SUM_W-1:0]    alu_a, alu_b, alu_c;
    ffsa_pkg::ffsa_cmp_t cmp;

    logic [AW-1:0]    seg_start, seg_end;
    logic [CNT_W-1:0] idx_inc, idx_dec, cnt_dec;
    logic [CAP_W-1:0] seg_after, seg_len;
    logic [SUM_W-1:0] new_end_w;
    logic             table_full, shrink_ok, can_double, table_empty;

    ffsa_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffsa_alu #(
        .W (SUM_W)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .c   (alu_c),
        .res (cmp)
    );

    assign seg_start   = mem_rdata[DW-1:AW];
    assign seg_end     = mem_rdata[AW-1:0];
    assign idx_inc     = idx_reg + 1'b1;
    assign idx_dec     = idx_reg - 1'b1;
    assign cnt_dec     = count_reg - 1'b1;
    assign seg_after   = CAP_W'(seg_end) + 1'b1;
    assign seg_len     = CAP_W'(seg_end) - CAP_W'(seg_start) + 1'b1;
    assign new_end_w   = SUM_W'(base_reg) + SUM_W'(need_reg) - 1'b1;
    assign table_full  = (count_reg == CNT_W'(MAX_SEGMENTS));
    assign table_empty = (count_reg == '0);
    assign shrink_ok   = (cap_reg > CAP_W'(ffsa_pkg::SHRINK_ABOVE));
    assign can_double  = !(work_cap_reg > CAP_W'(HALF_MAX));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffsa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type == ffsa_pkg::OP_FREE)
                    begin
                        state_next = table_empty ? ffsa_pkg::S_SHR_CHK : ffsa_pkg::S_FREE_RD;
                    end
                    else if (table_full)
                    begin
                        state_next = ffsa_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = table_empty ? ffsa_pkg::S_GROW : ffsa_pkg::S_ALLOC_RD;
                    end
                end
            end
            ffsa_pkg::S_ALLOC_RD:  state_next = ffsa_pkg::S_ALLOC_CMP;
            ffsa_pkg::S_ALLOC_CMP:
            begin
                if (cmp.ge)
                begin
                    state_next = ffsa_pkg::S_INS_RD;
                end
                else if (idx_inc == count_reg)
                begin
                    state_next = ffsa_pkg::S_GROW;
                end
                else
                begin
                    state_next = ffsa_pkg::S_ALLOC_RD;
                end
            end
            ffsa_pkg::S_GROW:
            begin
                if (cmp.ge)
                begin
                    state_next = ffsa_pkg::S_INS_PUT;
                end
                else if (!can_double)
                begin
                    state_next = ffsa_pkg::S_DONE;
                end
            end
            ffsa_pkg::S_INS_RD:    state_next = ffsa_pkg::S_INS_WR;
            ffsa_pkg::S_INS_WR:
            begin
                state_next = (idx_dec > pos_reg) ? ffsa_pkg::S_INS_RD : ffsa_pkg::S_INS_PUT;
            end
            ffsa_pkg::S_INS_PUT:   state_next = ffsa_pkg::S_DONE;
            ffsa_pkg::S_FREE_RD:   state_next = ffsa_pkg::S_FREE_CMP;
            ffsa_pkg::S_FREE_CMP:
            begin
                if (cmp.eq)
                begin
                    state_next = (idx_inc < count_reg) ? ffsa_pkg::S_DEL_RD
                                                       : ffsa_pkg::S_SHR_CHK;
                end
                else if (idx_inc == count_reg)
                begin
                    state_next = ffsa_pkg::S_SHR_CHK;
                end
                else
                begin
                    state_next = ffsa_pkg::S_FREE_RD;
                end
            end
            ffsa_pkg::S_DEL_RD:    state_next = ffsa_pkg::S_DEL_WR;
            ffsa_pkg::S_DEL_WR:
            begin
                state_next = (idx_inc < count_reg) ? ffsa_pkg::S_DEL_RD : ffsa_pkg::S_SHR_CHK;
            end
            ffsa_pkg::S_SHR_CHK:
            begin
                state_next = (shrink_ok && !table_empty) ? ffsa_pkg::S_SHR_RD
                                                         : ffsa_pkg::S_DONE;
            end
            ffsa_pkg::S_SHR_RD:    state_next = ffsa_pkg::S_SHR_CMP;
            ffsa_pkg::S_SHR_CMP:   state_next = ffsa_pkg::S_DONE;
            ffsa_pkg::S_DONE:
            begin
                if (done_ack)
                begin
                    state_next = ffsa_pkg::S_IDLE;
                end
            end
            default:               state_next = ffsa_pkg::S_IDLE;
        endcase
    end

    // Outputs: memory port, compare operands, status
    always_comb
    begin
        st.idle   = (state_reg == ffsa_pkg::S_IDLE);
        st.done   = (state_reg == ffsa_pkg::S_DONE);
        mem_we    = 1'b0;
        mem_waddr = idx_reg[IDX_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = idx_reg[IDX_W-1:0];
        alu_a     = SUM_W'(base_reg);
        alu_b     = SUM_W'(need_reg);
        alu_c     = SUM_W'(seg_start);
        unique case (state_reg)
            ffsa_pkg::S_INS_RD:  mem_raddr = idx_dec[IDX_W-1:0];
            ffsa_pkg::S_DEL_RD:  mem_raddr = idx_inc[IDX_W-1:0];
            ffsa_pkg::S_SHR_RD:  mem_raddr = cnt_dec[IDX_W-1:0];
            ffsa_pkg::S_INS_WR,
            ffsa_pkg::S_DEL_WR:  mem_we = 1'b1;
            ffsa_pkg::S_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[IDX_W-1:0];
                mem_wdata = {base_reg[AW-1:0], new_end_w[AW-1:0]};
            end
            ffsa_pkg::S_GROW:    alu_c = SUM_W'(work_cap_reg);
            ffsa_pkg::S_FREE_CMP:
            begin
                alu_a = SUM_W'(addr_reg);
                alu_b = '0;
            end
            ffsa_pkg::S_SHR_CMP:
            begin
                alu_a = SUM_W'(seg_end);
                alu_b = '0;
                alu_c = SUM_W'(cap_reg >> 2);
            end
            default:
            begin
            end
        endcase
        rsp.granted_address = grant_reg;
        rsp.status          = status_reg;
        rsp.used_words      = ffsa_pkg::WORD_W'(used_reg);
        rsp.capacity_now    = ffsa_pkg::WORD_W'(cap_reg);
    end

    // Datapath next values
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        cap_next      = cap_reg;
        work_cap_next = work_cap_reg;
        used_next     = used_reg;
        base_next     = base_reg;
        need_next     = need_reg;
        addr_next     = addr_reg;
        grant_next    = grant_reg;
        status_next   = status_reg;
        unique case (state_reg)
            ffsa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    addr_next     = req.free_address;
                    need_next     = NEED_W'(req.request_size) + 1'b1;
                    base_next     = '0;
                    idx_next      = '0;
                    work_cap_next = cap_reg;
                    grant_next    = '0;
                    if (req.req_type == ffsa_pkg::OP_FREE)
                    begin
                        status_next = ffsa_pkg::ST_NOTFOUND;
                    end
                    else
                    begin
                        status_next = table_full ? ffsa_pkg::ST_NOSPACE : ffsa_pkg::ST_OK;
                    end
                end
            end
            ffsa_pkg::S_ALLOC_CMP:
            begin
                if (cmp.ge)
                begin
                    pos_next = idx_reg;
                    idx_next = count_reg;
                end
                else
                begin
                    base_next = seg_after;
                    idx_next  = idx_inc;
                end
            end
            ffsa_pkg::S_GROW:
            begin
                if (cmp.ge)
                begin
                    cap_next = work_cap_reg;
                    pos_next = count_reg;
                    idx_next = count_reg;
                end
                else if (can_double)
                begin
                    work_cap_next = work_cap_reg << 1;
                end
                else
                begin
                    status_next = ffsa_pkg::ST_NOSPACE;
                end
            end
            ffsa_pkg::S_INS_WR:  idx_next = idx_dec;
            ffsa_pkg::S_INS_PUT:
            begin
                count_next  = count_reg + 1'b1;
                used_next   = used_reg + CAP_W'(need_reg);
                grant_next  = ffsa_pkg::ADDR_W'(base_reg);
                status_next = ffsa_pkg::ST_OK;
            end
            ffsa_pkg::S_FREE_CMP:
            begin
                if (cmp.eq)
                begin
                    used_next   = used_reg - seg_len;
                    count_next  = cnt_dec;
                    status_next = ffsa_pkg::ST_OK;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ffsa_pkg::S_DEL_WR:  idx_next = idx_inc;
            ffsa_pkg::S_SHR_CHK:
            begin
                if (shrink_ok && table_empty)
                begin
                    cap_next = cap_reg >> 1;
                end
            end
            ffsa_pkg::S_SHR_CMP:
            begin
                if (cmp.ge)
                begin
                    cap_next = cap_reg >> 1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffsa_pkg::S_IDLE;
            count_reg <= '0;
            cap_reg   <= CAP_W'(START_WORDS);
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        work_cap_reg <= work_cap_next;
        base_reg     <= base_next;
        need_reg     <= need_next;
        addr_reg     <= addr_next;
        grant_reg    <= grant_next;
        status_reg   <= status_next;
    end

endmodule

// ===== hw/rtl/first_fit_segment_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the first-fit segment allocator: request/result channels and result register.
//
// Usage:
//   req carries one request: req_type selects allocate or free, request_size is the
//   payload size of an allocation (one header word is added), free_address names the
//   segment start to release. rsp returns one result per request: granted address,
//   status, words in use and the arena capacity after the request.
//   Both channels use valid/ready; a request moves on a clock edge with both high.
//   A request walks the segment table entry by entry, through the single registered
//   read port of the table memory and the shared compare unit. The next request can be
//   taken in the cycle after the result loads. One request is in work at a time;
//   req.ready is high only while the sequencer is idle.
//   The result sits in an output register; the sequencer takes the next request while
//   a result waits there, and holds its own finished result until the register frees.
//   Reset: segment table empty, capacity START_WORDS, nothing in use. No clearing pass
//   runs; entries are only read once written.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS    = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int ARENA_MAX_WORDS = ffsa_pkg::ARENA_MAX_WORDS_DEF,
    parameter int START_WORDS     = ffsa_pkg::START_WORDS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ffsa_req_if.sink   req,
    ffsa_rsp_if.source rsp
);

    ffsa_pkg::ffsa_req_t     req_data;
    ffsa_pkg::ffsa_rsp_t     ctrl_rsp;
    ffsa_pkg::ffsa_ctrl_st_t ctrl_st;
    ffsa_pkg::ffsa_rsp_t     rsp_data_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    req_start;
    logic                    rsp_load;

    // Accept a request only while the sequencer is idle
    assign req.ready              = ctrl_st.idle;
    assign req_start              = req.valid & req.ready;
    assign req_data.req_type      = req.req_type;
    assign req_data.request_size  = req.request_size;
    assign req_data.free_address  = req.free_address;

    ffsa_ctrl #(
        .MAX_SEGMENTS    (MAX_SEGMENTS),
        .ARENA_MAX_WORDS (ARENA_MAX_WORDS),
        .START_WORDS     (START_WORDS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_data),
        .start    (req_start),
        .done_ack (rsp_load),
        .st       (ctrl_st),
        .rsp      (ctrl_rsp)
    );

    // Load the result register when it is empty or being drained this cycle
    assign rsp_load = ctrl_st.done & (~rsp_valid_reg | rsp.ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the payload while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_data_reg <= ctrl_rsp;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.granted_address = rsp_data_reg.granted_address;
    assign rsp.status          = rsp_data_reg.status;
    assign rsp.used_words      = rsp_data_reg.used_words;
    assign rsp.capacity_now    = rsp_data_reg.capacity_now;

    // A waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |-> !rsp_load)
        else $error("result register overwritten while stalled");

    // The block is busy in the cycle after it takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while previous one still in work");

    // Status is always one of the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == ffsa_pkg::ST_OK) || (rsp.status == ffsa_pkg::ST_NOSPACE)
                   || (rsp.status == ffsa_pkg::ST_NOTFOUND))
        else $error("undefined status code");

    // Failed requests grant no address
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ffsa_pkg::ST_OK) |-> (rsp.granted_address == '0))
        else $error("address granted on a failed request");

endmodule
